[hw/rtl/lps_pkg.sv]
`timescale 1ns / 1ps

package lps_pkg;

	// coordinate and span widths
	localparam int COORD_W = 16;
	localparam int SPAN_W  = COORD_W + 1;

	// visible window
	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 192;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [SPAN_W-1:0]  span_t;

	// command codes
	typedef enum logic {
		KIND_START = 1'b0,
		KIND_NEXT  = 1'b1
	} kind_t;

endpackage

[hw/rtl/lps_cmd_if.sv]
`timescale 1ns / 1ps

interface lps_cmd_if;
	import lps_pkg::*;

	logic   valid;
	logic   ready;
	kind_t  kind;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;

	modport source (output valid, output kind, output x_start, output y_start,
		output x_end, output y_end, input ready);
	modport sink (input valid, input kind, input x_start, input y_start,
		input x_end, input y_end, output ready);
endinterface

[hw/rtl/lps_pix_if.sv]
`timescale 1ns / 1ps

interface lps_pix_if;
	import lps_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   on_screen;
	logic   last;

	modport source (output valid, output pixel_x, output pixel_y, output on_screen,
		output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input on_screen,
		input last, output ready);
endinterface

[hw/rtl/line_pixel_stepper_top.sv]
`timescale 1ns / 1ps

// Line stepper: a start word (kind = start) loads two signed endpoints and yields no
// pixel; each following next word yields one pixel of the line, with an on-screen flag
// for the visible window and a last flag on the final pixel, after which the line ends
// and further next words are dropped without output. A start word may come at any time
// and replaces the line in progress. The line state and the single output register both
// update at the accept edge, so with next words and the sink always ready a pixel leaves
// every clock. The accumulator update is one add, one compare and subtract; the command
// side stalls only while the output register holds a pixel that the sink has not taken.
module line_pixel_stepper_top (
	input  logic           clk,
	input  logic           arst_n,
	lps_cmd_if.sink        cmd,
	lps_pix_if.source      pixel
);
	import lps_pkg::*;

	// line state
	coord_t cur_x_q, cur_y_q;
	logic   x_neg_q, y_neg_q;
	span_t  major_span_q, minor_span_q;
	span_t  error_acc_q, steps_done_q;
	logic   x_is_major_q;
	logic   active_q;

	// output register
	logic   out_valid_q;
	coord_t out_x_q, out_y_q;
	logic   out_on_q, out_last_q;

	// handshake: take a new word whenever the output register is free or draining
	logic acc, load_start, load_pixel;
	assign cmd.ready  = !out_valid_q || pixel.ready;
	assign acc        = cmd.valid && cmd.ready;
	assign load_start = acc && (cmd.kind == KIND_START);
	assign load_pixel = acc && (cmd.kind == KIND_NEXT) && active_q;

	// start word: spans and directions from the endpoint differences
	logic signed [SPAN_W-1:0] dx, dy;
	span_t abs_dx, abs_dy, span_x, span_y;
	logic  start_x_major;

	always_comb begin
		dx = SPAN_W'($signed({cmd.x_end[COORD_W-1], cmd.x_end}))
			- SPAN_W'($signed({cmd.x_start[COORD_W-1], cmd.x_start}));
		dy = SPAN_W'($signed({cmd.y_end[COORD_W-1], cmd.y_end}))
			- SPAN_W'($signed({cmd.y_start[COORD_W-1], cmd.y_start}));
		abs_dx = dx[SPAN_W-1] ? span_t'(-dx) : span_t'(dx);
		abs_dy = dy[SPAN_W-1] ? span_t'(-dy) : span_t'(dy);
		// zero difference still spans one pixel
		span_x = abs_dx + span_t'(1);
		span_y = abs_dy + span_t'(1);
		// ties go to x
		start_x_major = (span_x >= span_y);
	end

	// next word: current pixel out, then one step along the line
	logic [SPAN_W:0] err_sum;
	logic            minor_hit;
	span_t           err_next, steps_next;
	logic            last_c, on_c;
	coord_t          x_step, y_step, x_next, y_next;

	always_comb begin
		steps_next = steps_done_q + span_t'(1);
		last_c     = (steps_next >= major_span_q);

		// visible when both coordinates are non-negative and inside the window
		on_c = !cur_x_q[COORD_W-1] && !cur_y_q[COORD_W-1]
			&& (32'(unsigned'(cur_x_q)) < 32'(SCREEN_WIDTH))
			&& (32'(unsigned'(cur_y_q)) < 32'(SCREEN_HEIGHT));

		// accumulate the minor span, no half-step offset
		err_sum   = {1'b0, error_acc_q} + {1'b0, minor_span_q};
		minor_hit = (err_sum >= {1'b0, major_span_q});
		err_next  = minor_hit ? SPAN_W'(err_sum - {1'b0, major_span_q}) : SPAN_W'(err_sum);

		x_step = x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
		y_step = y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);

		// major axis always moves, minor axis only on an accumulator hit
		if (x_is_major_q) begin
			x_next = x_step;
			y_next = minor_hit ? y_step : cur_y_q;
		end else begin
			x_next = minor_hit ? x_step : cur_x_q;
			y_next = y_step;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			x_is_major_q <= 1'b1;
			x_neg_q      <= 1'b0;
			y_neg_q      <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			major_span_q <= '0;
			minor_span_q <= '0;
			error_acc_q  <= '0;
			steps_done_q <= '0;
		end else if (load_start) begin
			active_q     <= 1'b1;
			x_is_major_q <= start_x_major;
			x_neg_q      <= dx[SPAN_W-1];
			y_neg_q      <= dy[SPAN_W-1];
			cur_x_q      <= cmd.x_start;
			cur_y_q      <= cmd.y_start;
			major_span_q <= start_x_major ? span_x : span_y;
			minor_span_q <= start_x_major ? span_y : span_x;
			error_acc_q  <= '0;
			steps_done_q <= '0;
		end else if (load_pixel) begin
			cur_x_q      <= x_next;
			cur_y_q      <= y_next;
			error_acc_q  <= err_next;
			steps_done_q <= steps_next;
			// line ends after its final pixel
			if (last_c) begin
				active_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pixel) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_pixel) begin
			out_x_q    <= cur_x_q;
			out_y_q    <= cur_y_q;
			out_on_q   <= on_c;
			out_last_q <= last_c;
		end
	end

	assign pixel.valid     = out_valid_q;
	assign pixel.pixel_x   = out_x_q;
	assign pixel.pixel_y   = out_y_q;
	assign pixel.on_screen = out_on_q;
	assign pixel.last      = out_last_q;

`ifndef SYNTHESIS
	// accumulator stays below the major span while a line runs
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (error_acc_q < major_span_q))
		else $error("accumulator reached major span");

	// a start word arms a fresh line
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		load_start |=> (active_q && steps_done_q == '0 && error_acc_q == '0))
		else $error("start word did not arm the line");

	// the final pixel closes the line and leaves a last pixel in the output register
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_pixel && last_c) |=> (!active_q && pixel.valid && pixel.last))
		else $error("line still active after last pixel");

	// a stalled output word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pixel.ready) |-> !load_pixel)
		else $error("pending pixel overwritten");
`endif

endmodule
